// File: hdl/knn_pkg.sv
// Shared widths, request codes and queue entry type for the nearest-neighbor search block.
package knn_pkg;

	localparam int DIM_W = 11;
	localparam logic [DIM_W-1:0] DIM_RESET = 11'd128;
	localparam int REQ_W = 2;
	localparam int COMP_W = 16;
	localparam int SQ_W = 32;
	localparam int DIST_W = 48;
	localparam int ID_W = 24;
	localparam int RANK_W = 6;

	localparam logic [REQ_W-1:0] REQ_QUERY = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DB = 2'd1;
	localparam logic [REQ_W-1:0] REQ_FINISH = 2'd2;

	localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

	localparam int LIST_DEPTH_DEF = 64;
	localparam int MAX_DIM_DEF = 1024;
	localparam int QUEUE_DEPTH = 8;

	// one command from the front end to the list keeper
	typedef struct packed {
		logic fin;
		logic ovf;
		logic [DIST_W-1:0] sq_dist;
		logic [ID_W-1:0] id;
	} cmd_t;

	// queue read side
	typedef struct packed {
		logic avail;
		cmd_t head;
	} qstat_t;

endpackage

// File: hdl/knn_req_if.sv
// Request channel: query and database components and the finish request.
interface knn_req_if;
	logic valid;
	logic ready;
	logic [knn_pkg::REQ_W-1:0] req_type;
	logic signed [knn_pkg::COMP_W-1:0] component;

	modport source(output valid, req_type, component, input ready);
	modport sink(input valid, req_type, component, output ready);
endinterface

// File: hdl/knn_res_if.sv
// Result channel: one ranked entry of the nearest list per item.
interface knn_res_if;
	logic valid;
	logic ready;
	logic [knn_pkg::RANK_W-1:0] rank;
	logic [knn_pkg::ID_W-1:0] vector_id;
	logic [knn_pkg::DIST_W-1:0] distance;
	logic valid_res;
	logic id_overflow;
	logic last;

	modport source(output valid, rank, vector_id, distance, valid_res, id_overflow, last,
		input ready);
	modport sink(input valid, rank, vector_id, distance, valid_res, id_overflow, last,
		output ready);
endinterface

// File: hdl/knn_cfg_if.sv
// Configuration write channel for the dimension register.
interface knn_cfg_if;
	logic valid;
	logic ready;
	logic [knn_pkg::DIM_W-1:0] dimension;

	modport source(output valid, dimension, input ready);
	modport sink(input valid, dimension, output ready);
endinterface

// File: hdl/knn_front.sv
// Front end: query store, distance pipeline and vector id assignment.
module knn_front #(
	parameter int MAX_DIMENSION = knn_pkg::MAX_DIM_DEF,
	parameter int QD = knn_pkg::QUEUE_DEPTH,
	localparam int IDX_W = $clog2(MAX_DIMENSION),
	localparam int CNT_W = IDX_W + 1,
	localparam int QCNT_W = $clog2(QD + 1)
) (
	input logic clk,
	input logic arst_n,
	knn_req_if.sink req,
	input logic [CNT_W-1:0] dim_eff,
	input logic [QCNT_W-1:0] q_count,
	output logic push,
	output knn_pkg::cmd_t push_cmd
);

	logic signed [knn_pkg::COMP_W-1:0] qmem [MAX_DIMENSION];

	logic [IDX_W-1:0] ci_q, qi_q, qi_eff;
	logic [knn_pkg::ID_W-1:0] cnt_q;
	logic ovf_q;
	logic [knn_pkg::DIST_W-1:0] acc_q, acc_sum;
	logic accept, is_q, is_db, is_fin, vec_end;
	logic [CNT_W-1:0] ci_next, qi_next;
	logic [QCNT_W:0] level;

	logic v_s1, fin_s1, end_s1, ovf_s1;
	logic [knn_pkg::ID_W-1:0] id_s1;
	logic signed [knn_pkg::COMP_W-1:0] q_s1, comp_s1;
	logic v_s2, fin_s2, end_s2, ovf_s2;
	logic [knn_pkg::ID_W-1:0] id_s2;
	logic [knn_pkg::SQ_W-1:0] sq_s2;
	logic signed [knn_pkg::COMP_W:0] diff;
	logic signed [2*knn_pkg::COMP_W+1:0] prod;

	// every item in flight may end up in the queue
	assign level = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(v_s1) + (QCNT_W+1)'(v_s2);
	assign req.ready = level < (QCNT_W+1)'(QD);
	assign accept = req.valid & req.ready;
	assign is_q = req.req_type == knn_pkg::REQ_QUERY;
	assign is_db = req.req_type == knn_pkg::REQ_DB;
	assign is_fin = req.req_type == knn_pkg::REQ_FINISH;

	assign qi_eff = (CNT_W'(qi_q) >= dim_eff) ? '0 : qi_q;
	assign qi_next = CNT_W'(qi_eff) + CNT_W'(1);
	assign ci_next = CNT_W'(ci_q) + CNT_W'(1);
	assign vec_end = ci_next >= dim_eff;

	always_ff @(posedge clk) begin
		if (accept && is_q) begin
			qmem[qi_eff] <= req.component;
		end
		if (accept && is_db) begin
			q_s1 <= qmem[ci_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ci_q <= '0;
			qi_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept && (is_db || is_fin);
			if (accept && is_q) begin
				qi_q <= (qi_next >= dim_eff) ? '0 : qi_next[IDX_W-1:0];
			end
			if (accept && is_db) begin
				ci_q <= vec_end ? '0 : ci_next[IDX_W-1:0];
				if (vec_end) begin
					if (cnt_q == knn_pkg::ID_MAX) begin
						ovf_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
			end
			if (accept && is_fin) begin
				ci_q <= '0;
				qi_q <= '0;
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		fin_s1 <= is_fin;
		end_s1 <= vec_end;
		id_s1 <= cnt_q;
		ovf_s1 <= ovf_q;
		comp_s1 <= req.component;
	end

	assign diff = (knn_pkg::COMP_W+1)'(q_s1) - (knn_pkg::COMP_W+1)'(comp_s1);
	assign prod = diff * diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		fin_s2 <= fin_s1;
		end_s2 <= end_s1;
		id_s2 <= id_s1;
		ovf_s2 <= ovf_s1;
		sq_s2 <= prod[knn_pkg::SQ_W-1:0];
	end

	assign acc_sum = acc_q + knn_pkg::DIST_W'(sq_s2);
	assign push = v_s2 && (fin_s2 || end_s2);
	assign push_cmd.fin = fin_s2;
	assign push_cmd.ovf = ovf_s2;
	assign push_cmd.sq_dist = acc_sum;
	assign push_cmd.id = id_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= (fin_s2 || end_s2) ? '0 : acc_sum;
		end
	end

endmodule

// File: hdl/knn_queue.sv
// Small command queue between the front end and the list keeper.
module knn_queue #(
	parameter int DEPTH = knn_pkg::QUEUE_DEPTH,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int QCNT_W = $clog2(DEPTH + 1)
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input knn_pkg::cmd_t push_cmd,
	input logic pop,
	output knn_pkg::qstat_t stat,
	output logic [QCNT_W-1:0] count
);

	knn_pkg::cmd_t slots [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic do_pop;

	assign do_pop = pop && (cnt_q != '0);
	assign count = cnt_q;
	assign stat.avail = cnt_q != '0;
	assign stat.head = slots[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: hdl/knn_back.sv
// List keeper: sorted row of best-K cells, insertion and ranked emission.
module knn_back #(
	parameter int LIST_DEPTH = knn_pkg::LIST_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input knn_pkg::qstat_t qstat,
	output logic pop,
	knn_res_if.source res
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic state_q;
	logic [knn_pkg::RANK_W-1:0] rank_q;
	logic fovf_q;

	logic [knn_pkg::DIST_W-1:0] dist_q [LIST_DEPTH];
	logic [knn_pkg::ID_W-1:0] id_q [LIST_DEPTH];
	logic val_q [LIST_DEPTH];
	logic [knn_pkg::DIST_W-1:0] dist_n [LIST_DEPTH];
	logic [knn_pkg::ID_W-1:0] id_n [LIST_DEPTH];
	logic val_n [LIST_DEPTH];
	logic worse [LIST_DEPTH];

	logic do_ins, load, is_last;
	logic out_v_q, o_valid_q, o_ovf_q, o_last_q;
	logic [knn_pkg::RANK_W-1:0] o_rank_q;
	logic [knn_pkg::ID_W-1:0] o_id_q;
	logic [knn_pkg::DIST_W-1:0] o_dist_q;

	assign pop = (state_q == ST_IDLE) && qstat.avail;
	assign do_ins = pop && !qstat.head.fin;
	assign load = (state_q == ST_EMIT) && (!out_v_q || res.ready);
	assign is_last = rank_q == knn_pkg::RANK_W'(LIST_DEPTH - 1);

	// each cell compares against the incoming distance; empty cells rank last
	always_comb begin
		for (int k = 0; k < LIST_DEPTH; k++) begin
			worse[k] = !val_q[k] || (dist_q[k] > qstat.head.sq_dist);
		end
		for (int k = 0; k < LIST_DEPTH; k++) begin
			dist_n[k] = dist_q[k];
			id_n[k] = id_q[k];
			val_n[k] = val_q[k];
			if (load) begin
				if (k == LIST_DEPTH - 1) begin
					val_n[k] = 1'b0;
				end else begin
					dist_n[k] = dist_q[(k + 1) % LIST_DEPTH];
					id_n[k] = id_q[(k + 1) % LIST_DEPTH];
					val_n[k] = val_q[(k + 1) % LIST_DEPTH];
				end
			end else if (do_ins) begin
				if (k > 0 && worse[(k + LIST_DEPTH - 1) % LIST_DEPTH]) begin
					dist_n[k] = dist_q[(k + LIST_DEPTH - 1) % LIST_DEPTH];
					id_n[k] = id_q[(k + LIST_DEPTH - 1) % LIST_DEPTH];
					val_n[k] = val_q[(k + LIST_DEPTH - 1) % LIST_DEPTH];
				end else if (worse[k]) begin
					dist_n[k] = qstat.head.sq_dist;
					id_n[k] = qstat.head.id;
					val_n[k] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < LIST_DEPTH; k++) begin
			dist_q[k] <= dist_n[k];
			id_q[k] <= id_n[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LIST_DEPTH; k++) begin
				val_q[k] <= 1'b0;
			end
		end else begin
			for (int k = 0; k < LIST_DEPTH; k++) begin
				val_q[k] <= val_n[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rank_q <= '0;
			fovf_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop && qstat.head.fin) begin
						state_q <= ST_EMIT;
						rank_q <= '0;
						fovf_q <= qstat.head.ovf;
					end
				end
				ST_EMIT: begin
					if (load) begin
						rank_q <= rank_q + 1'b1;
						if (is_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load) begin
				out_v_q <= 1'b1;
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			o_rank_q <= rank_q;
			o_valid_q <= val_q[0];
			o_id_q <= val_q[0] ? id_q[0] : '0;
			o_dist_q <= val_q[0] ? dist_q[0] : '0;
			o_ovf_q <= fovf_q;
			o_last_q <= is_last;
		end
	end

	assign res.valid = out_v_q;
	assign res.rank = o_rank_q;
	assign res.vector_id = o_id_q;
	assign res.distance = o_dist_q;
	assign res.valid_res = o_valid_q;
	assign res.id_overflow = o_ovf_q;
	assign res.last = o_last_q;

endmodule

// File: hdl/knn_squared_l2_top_k.sv
// Top level of the exact squared-L2 nearest-neighbor search with a sorted best-K list.
// Query components (req_type 0) fill the query store in order; database components
// (req_type 1) stream in and each vector of `dimension` components gets an exact 48-bit
// squared distance and an id in arrival order. A front end accepts one request item per
// clock unless stalled: it reads the query store, squares the difference and
// accumulates over a pipeline, then hands each finished vector or finish request to an
// 8-entry queue. While idle, the list keeper pops one command per clock and inserts
// into all LIST_DEPTH cells in parallel. A finish (req_type 2) makes it emit LIST_DEPTH
// result items at up to one per clock, shifting the list out so it is empty afterward;
// during emission no insertion runs, new vectors wait in the queue, and the request
// side stalls once the queue entries plus the items in the two front pipeline stages
// reach eight. The configuration port is always ready; write dimension only while no
// item is in progress.
module knn_squared_l2_top_k #(
	parameter int LIST_DEPTH = knn_pkg::LIST_DEPTH_DEF,
	parameter int MAX_DIMENSION = knn_pkg::MAX_DIM_DEF
) (
	input logic clk,
	input logic arst_n,
	knn_cfg_if.sink cfg,
	knn_req_if.sink req,
	knn_res_if.source res
);

	localparam int CNT_W = $clog2(MAX_DIMENSION) + 1;
	localparam int XW = (knn_pkg::DIM_W > CNT_W) ? knn_pkg::DIM_W : CNT_W;
	localparam int QD = knn_pkg::QUEUE_DEPTH;
	localparam int QCNT_W = $clog2(QD + 1);

	logic [knn_pkg::DIM_W-1:0] dim_q;
	logic [XW-1:0] dim_x, dim_clip;
	logic [CNT_W-1:0] dim_eff;
	logic push, pop;
	knn_pkg::cmd_t push_cmd;
	knn_pkg::qstat_t qstat;
	logic [QCNT_W-1:0] q_count;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= knn_pkg::DIM_RESET;
		end else if (cfg.valid) begin
			dim_q <= cfg.dimension;
		end
	end

	// zero acts as one, oversize values clip to the store depth
	assign dim_x = XW'(dim_q);
	assign dim_clip = (dim_x == '0) ? XW'(1) :
		(dim_x > XW'(MAX_DIMENSION)) ? XW'(MAX_DIMENSION) : dim_x;
	assign dim_eff = dim_clip[CNT_W-1:0];

	knn_front #(
		.MAX_DIMENSION(MAX_DIMENSION),
		.QD(QD)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.dim_eff(dim_eff),
		.q_count(q_count),
		.push(push),
		.push_cmd(push_cmd)
	);

	knn_queue #(
		.DEPTH(QD)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.pop(pop),
		.stat(qstat),
		.count(q_count)
	);

	knn_back #(
		.LIST_DEPTH(LIST_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.qstat(qstat),
		.pop(pop),
		.res(res)
	);

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (q_count < QCNT_W'(QD) || pop))
		else $error("command queue written while full");

	a_last_rank: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.last) |-> (res.rank == knn_pkg::RANK_W'(LIST_DEPTH - 1)))
		else $error("last flag on wrong rank");

	a_empty_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.valid_res) |-> (res.distance == '0 && res.vector_id == '0))
		else $error("empty slot carries data");

	a_pop_avail: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qstat.avail)
		else $error("pop from empty queue");

endmodule

// File: bench/knn_squared_l2_top_k_tb.sv
// Self-checking bench for the squared-L2 nearest-neighbor search with its sorted best-K list.
module knn_squared_l2_top_k_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = knn_pkg::LIST_DEPTH_DEF;
	localparam int MAXD = knn_pkg::MAX_DIM_DEF;
	localparam int unsigned CYCLE_LIMIT = 200_000;
	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 70;
	localparam int WARM_DIM = 24;
	localparam logic [knn_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

	typedef enum int {SPREAD_WIDE, SPREAD_NARROW, SPREAD_EXTREME} spread_t;

	typedef struct packed {
		logic [knn_pkg::REQ_W-1:0] kind;
		logic signed [knn_pkg::COMP_W-1:0] comp;
	} req_item_t;

	typedef struct packed {
		logic [knn_pkg::RANK_W-1:0] rank;
		logic [knn_pkg::ID_W-1:0] vector_id;
		logic [knn_pkg::DIST_W-1:0] distance;
		logic valid_res;
		logic id_overflow;
		logic last;
	} list_entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	knn_cfg_if cfg_bus();
	knn_req_if req_bus();
	knn_res_if res_bus();

	knn_squared_l2_top_k uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.req(req_bus),
		.res(res_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// search state as the block should hold it
	logic [knn_pkg::DIM_W-1:0] dim_reg;
	logic [knn_pkg::COMP_W-1:0] query_mem [MAXD];
	int unsigned comp_pos;
	int unsigned query_pos;
	logic [knn_pkg::DIST_W-1:0] dist_acc;
	logic [knn_pkg::ID_W-1:0] next_id;
	logic [knn_pkg::DIST_W-1:0] near_dist [DEPTH];
	logic [knn_pkg::ID_W-1:0] near_id [DEPTH];
	bit near_used [DEPTH];
	bit id_saturated;
	list_entry_t due_entries[$];

	function automatic int unsigned active_dim();
		if (dim_reg == '0)
			return 1;
		if (dim_reg > MAXD)
			return MAXD;
		return dim_reg;
	endfunction

	task automatic clear_search();
		for (int k = 0; k < DEPTH; k++) begin
			near_dist[k] = '1;
			near_id[k] = '0;
			near_used[k] = 1'b0;
		end
		comp_pos = 0;
		query_pos = 0;
		dist_acc = '0;
		next_id = '0;
		id_saturated = 1'b0;
	endtask

	// ties rank after the entry already there
	task automatic insert_nearest(input logic [knn_pkg::DIST_W-1:0] d,
		input logic [knn_pkg::ID_W-1:0] id);
		int pos;
		pos = DEPTH - 1;
		if (near_used[pos] && !(near_dist[pos] > d))
			return;
		while (pos > 0 && (!near_used[pos-1] || near_dist[pos-1] > d)) begin
			near_dist[pos] = near_dist[pos-1];
			near_id[pos] = near_id[pos-1];
			near_used[pos] = near_used[pos-1];
			pos--;
		end
		near_dist[pos] = d;
		near_id[pos] = id;
		near_used[pos] = 1'b1;
	endtask

	task automatic search_step(input req_item_t it);
		int unsigned d;
		int unsigned pos;
		longint diff;
		list_entry_t e;
		d = active_dim();
		case (it.kind)
			knn_pkg::REQ_QUERY: begin
				pos = (query_pos >= d) ? 0 : query_pos;
				query_mem[pos] = it.comp;
				query_pos = (pos + 1 >= d) ? 0 : pos + 1;
			end
			knn_pkg::REQ_DB: begin
				pos = (comp_pos >= MAXD) ? MAXD - 1 : comp_pos;
				diff = longint'($signed(query_mem[pos])) - longint'($signed(it.comp));
				dist_acc = dist_acc + knn_pkg::DIST_W'(diff * diff);
				if (pos + 1 >= d) begin
					insert_nearest(dist_acc, next_id);
					if (next_id == knn_pkg::ID_MAX)
						id_saturated = 1'b1;
					else
						next_id++;
					dist_acc = '0;
					comp_pos = 0;
				end else begin
					comp_pos = pos + 1;
				end
			end
			knn_pkg::REQ_FINISH: begin
				for (int k = 0; k < DEPTH; k++) begin
					e.rank = knn_pkg::RANK_W'(k);
					e.vector_id = near_used[k] ? near_id[k] : '0;
					e.distance = near_used[k] ? near_dist[k] : '0;
					e.valid_res = near_used[k];
					e.id_overflow = id_saturated;
					e.last = (k == DEPTH - 1);
					due_entries.insert(due_entries.size(), e);
				end
				clear_search();
			end
			default: begin
			end
		endcase
	endtask

	function automatic int pick_gap(inout bit quiet);
		int r;
		if ($urandom_range(0, 59) == 0)
			quiet = !quiet;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// request side
	req_item_t req_backlog[$];
	req_item_t offered;
	bit req_taken;
	bit req_quiet;
	int req_gap;

	always @(posedge clk) begin
		if (arst_n && req_bus.valid && req_bus.ready) begin
			search_step(offered);
			req_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
		end else if (!req_bus.valid || req_taken) begin
			req_taken = 1'b0;
			if (req_gap > 0) begin
				req_bus.valid <= 1'b0;
				req_gap--;
			end else if (req_backlog.size() != 0) begin
				offered = req_backlog.pop_front();
				req_bus.req_type <= offered.kind;
				req_bus.component <= offered.comp;
				req_bus.valid <= 1'b1;
				req_gap = pick_gap(req_quiet);
			end else begin
				req_bus.valid <= 1'b0;
			end
		end
	end

	// result side
	bit res_quiet;
	int res_gap;
	int hold_left;
	int holds_asked;
	int holds_done;
	int mismatch_count;

	always @(negedge clk) begin
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
		end else if (hold_left > 0) begin
			res_bus.ready <= 1'b0;
			hold_left--;
		end else if (holds_asked != holds_done) begin
			holds_done++;
			hold_left = HOLD_CYCLES - 1;
			res_bus.ready <= 1'b0;
		end else if (res_gap > 0) begin
			res_bus.ready <= 1'b0;
			res_gap--;
		end else begin
			res_bus.ready <= 1'b1;
			res_gap = pick_gap(res_quiet);
		end
	end

	function automatic bit field_ok(input string name, input logic [knn_pkg::DIST_W-1:0] want,
		input logic [knn_pkg::DIST_W-1:0] got);
		if (want === got)
			return 1'b1;
		$error("%s: expected %0d, got %0d", name, want, got);
		return 1'b0;
	endfunction

	always @(posedge clk) begin
		list_entry_t e;
		bit ok;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (due_entries.size() == 0) begin
				$error("result item with nothing expected, rank %0d", res_bus.rank);
				mismatch_count++;
			end else begin
				e = due_entries.pop_front();
				ok = field_ok("rank", e.rank, res_bus.rank);
				ok &= field_ok("vector_id", e.vector_id, res_bus.vector_id);
				ok &= field_ok("distance", e.distance, res_bus.distance);
				ok &= field_ok("valid_res", e.valid_res, res_bus.valid_res);
				ok &= field_ok("id_overflow", e.id_overflow, res_bus.id_overflow);
				ok &= field_ok("last", e.last, res_bus.last);
				if (!ok)
					mismatch_count++;
			end
		end
	end

	int unsigned cycle_count;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// stimulus helpers
	task automatic send(input logic [knn_pkg::REQ_W-1:0] kind,
		input logic signed [knn_pkg::COMP_W-1:0] comp);
		req_item_t it;
		it.kind = kind;
		it.comp = comp;
		req_backlog.insert(req_backlog.size(), it);
	endtask

	// block is idle once every item is in, every entry is out and the queue has drained
	task automatic settle();
		do
			@(posedge clk);
		while (req_backlog.size() != 0 || req_bus.valid);
		while (due_entries.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_dim(input logic [knn_pkg::DIM_W-1:0] v);
		@(negedge clk);
		cfg_bus.dimension <= v;
		cfg_bus.valid <= 1'b1;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		dim_reg = v;
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	function automatic logic signed [knn_pkg::COMP_W-1:0] pick_component(input spread_t spread);
		case (spread)
			SPREAD_WIDE: return knn_pkg::COMP_W'($urandom);
			SPREAD_NARROW: return knn_pkg::COMP_W'($urandom_range(0, 8) - 4);
			default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
		endcase
	endfunction

	logic signed [knn_pkg::COMP_W-1:0] query_copy [MAXD];

	initial begin
		int unsigned eff;
		int unsigned n;
		int unsigned tail;
		int unsigned count;
		logic [knn_pkg::DIM_W-1:0] d;
		spread_t spread;
		req_bus.valid = 1'b0;
		req_bus.req_type = knn_pkg::REQ_QUERY;
		req_bus.component = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.dimension = knn_pkg::DIM_RESET;
		res_bus.ready = 1'b0;
		dim_reg = knn_pkg::DIM_RESET;
		clear_search();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fills the query entries used later; exact match ranks first, unused type dropped
		write_dim(knn_pkg::DIM_W'(WARM_DIM));
		for (int i = 0; i < WARM_DIM; i++) begin
			case (i)
				0: query_copy[i] = 16'sh7fff;
				1: query_copy[i] = 16'sh8000;
				2: query_copy[i] = -16'sd1;
				default: query_copy[i] = pick_component(SPREAD_WIDE);
			endcase
			send(knn_pkg::REQ_QUERY, query_copy[i]);
		end
		send(REQ_UNUSED, 16'sh5a5a);
		for (int i = 0; i < WARM_DIM; i++)
			send(knn_pkg::REQ_DB, pick_component(SPREAD_WIDE));
		for (int i = 0; i < WARM_DIM; i++)
			send(knn_pkg::REQ_DB, query_copy[i]);
		send(knn_pkg::REQ_FINISH, '0);
		settle();

		// zero acts as one; ties keep arrival order; finish on an empty list
		write_dim('0);
		send(knn_pkg::REQ_QUERY, 16'sd5);
		send(knn_pkg::REQ_DB, 16'sd5);
		send(knn_pkg::REQ_DB, 16'sd7);
		send(knn_pkg::REQ_DB, 16'sd3);
		send(knn_pkg::REQ_QUERY, 16'sh8000);
		send(knn_pkg::REQ_DB, 16'sh7fff);
		send(knn_pkg::REQ_DB, 16'sh8000);
		send(knn_pkg::REQ_FINISH, '0);
		send(knn_pkg::REQ_FINISH, '0);
		settle();

		// register above the store size acts as the full size: no vector ends here
		write_dim('1);
		send(knn_pkg::REQ_DB, 16'sh7fff);
		send(knn_pkg::REQ_DB, 16'sh8000);
		send(knn_pkg::REQ_DB, 16'sd1);
		send(knn_pkg::REQ_FINISH, '0);
		settle();

		// shrink the dimension with a vector and a query half done
		write_dim(11'd4);
		send(knn_pkg::REQ_QUERY, 16'sd1);
		send(knn_pkg::REQ_QUERY, 16'sd2);
		send(knn_pkg::REQ_QUERY, 16'sd3);
		send(knn_pkg::REQ_DB, 16'sd10);
		send(knn_pkg::REQ_DB, 16'sd20);
		send(knn_pkg::REQ_DB, 16'sd30);
		settle();
		write_dim(11'd2);
		send(knn_pkg::REQ_QUERY, 16'sd9);
		send(knn_pkg::REQ_DB, 16'sd40);
		send(knn_pkg::REQ_DB, 16'sd1);
		send(knn_pkg::REQ_DB, -16'sd2);
		send(knn_pkg::REQ_FINISH, '0);
		settle();

		// long receiver hold while vectors keep coming; second list overfills with ties
		write_dim(11'd1);
		holds_asked++;
		for (int i = 0; i < 10; i++)
			send(knn_pkg::REQ_DB, pick_component(SPREAD_WIDE));
		send(knn_pkg::REQ_FINISH, '0);
		for (int i = 0; i < 70; i++)
			send(knn_pkg::REQ_DB, pick_component(SPREAD_NARROW));
		send(knn_pkg::REQ_FINISH, '0);
		settle();

		count = 0;
		while (count < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: d = '0;
				1, 2, 3, 4: d = knn_pkg::DIM_W'($urandom_range(1, 3));
				5, 6, 7: d = knn_pkg::DIM_W'($urandom_range(4, 12));
				default: d = knn_pkg::DIM_W'($urandom_range(13, WARM_DIM));
			endcase
			write_dim(d);
			eff = active_dim();
			spread = spread_t'($urandom_range(0, 2));
			if ($urandom_range(0, 1)) begin
				for (int i = 0; i < eff; i++)
					send(knn_pkg::REQ_QUERY, pick_component(spread));
				count += eff;
			end
			n = $urandom_range(1, (eff <= 2) ? 24 : 40 / eff + 1);
			for (int v = 0; v < n; v++) begin
				for (int i = 0; i < eff; i++) begin
					if ($urandom_range(0, 19) == 0) begin
						send(knn_pkg::REQ_QUERY, pick_component(spread));
						count++;
					end
					if ($urandom_range(0, 49) == 0)
						send(REQ_UNUSED, pick_component(SPREAD_WIDE));
					send(knn_pkg::REQ_DB, pick_component(spread));
					count++;
				end
			end
			if ($urandom_range(0, 4) != 0 || eff == 1) begin
				send(knn_pkg::REQ_FINISH, pick_component(SPREAD_WIDE));
				count++;
			end else begin
				// leave a vector partly received for the next dimension
				tail = $urandom_range(1, eff - 1);
				for (int i = 0; i < tail; i++) begin
					send(knn_pkg::REQ_DB, pick_component(spread));
					count++;
				end
			end
			settle();
		end
		send(knn_pkg::REQ_FINISH, '0);
		settle();

		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: files.f
hdl/knn_pkg.sv
hdl/knn_req_if.sv
hdl/knn_res_if.sv
hdl/knn_cfg_if.sv
hdl/knn_front.sv
hdl/knn_queue.sv
hdl/knn_back.sv
hdl/knn_squared_l2_top_k.sv
bench/knn_squared_l2_top_k_tb.sv
